>>> rtl/mrf_pkg.sv
// Shared types, register codes and the CRC-16 byte step for the motor command framer.
`timescale 1ns / 1ps

package mrf_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_MODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_CMD    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_ADDR    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_ADDR     = 4'd3;

  localparam logic [15:0] VELOCITY_MODE_RST = 16'h0003;
  localparam logic [15:0] ENABLE_CMD_RST    = 16'h0008;
  localparam logic [7:0]  FRONT_ADDR_RST    = 8'h01;
  localparam logic [7:0]  BACK_ADDR_RST     = 8'h02;

  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] REG_MODE          = 16'h200D;
  localparam logic [15:0] REG_CONTROL       = 16'h200E;
  localparam logic [15:0] REG_SPEED_LEFT    = 16'h2088;
  localparam logic [15:0] REG_SPEED_RIGHT   = 16'h2089;
  localparam logic [15:0] REG_NODE_ADDR     = 16'h2001;
  localparam logic [15:0] REG_EEPROM_SAVE   = 16'h2010;
  localparam logic [15:0] SAVE_VALUE        = 16'h0001;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;

  localparam logic       OP_SET_SPEED   = 1'b0;
  localparam logic [2:0] BYTE_CRC_LO    = 3'd6;
  localparam logic [2:0] BYTE_LAST      = 3'd7;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } seq_state_t;

  typedef enum logic [2:0] {
    FR_MODE,
    FR_ENABLE,
    FR_SPEED,
    FR_NEW_ADDR,
    FR_SAVE
  } frame_kind_t;

  typedef struct packed {
    logic       update;
    logic       first;
    logic [7:0] data;
  } crc_ctl_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       last;
  } emit_t;

  // One byte through the reflected CRC-16, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

>>> rtl/mrf_crc.sv
// CRC-16 accumulator, advanced one frame byte per cycle while its update input is high.
`timescale 1ns / 1ps

module mrf_crc (
  input  logic              clk,
  input  mrf_pkg::crc_ctl_t ctl,
  output logic [15:0]       crc
);
  import mrf_pkg::*;

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;

  always_comb begin
    crc_nxt = crc_r;
    if (ctl.update) begin
      crc_nxt = crc16_byte(ctl.first ? CRC_INIT : crc_r, ctl.data);
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign crc = crc_r;

endmodule

>>> rtl/mrf_seq.sv
// Frame sequencer: plans the frames of a command and walks their bytes.
`timescale 1ns / 1ps

module mrf_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            operation,
  input  logic [7:0]      drive_addr,
  input  logic            wheel_side,
  input  logic [15:0]     command_value,
  input  logic [15:0]     velocity_mode_code,
  input  logic [15:0]     enable_command,
  input  logic [7:0]      front_drive_address,
  input  logic [7:0]      back_drive_address,
  input  logic            emit_ok,
  output logic            busy,
  output mrf_pkg::emit_t  emit
);
  import mrf_pkg::*;

  seq_state_t  state_r, state_nxt;
  frame_kind_t kind_r, kind_nxt, start_kind;
  logic [2:0]  byte_idx_r;
  logic [7:0]  addr_r;
  logic        side_r;
  logic [15:0] val_r;
  logic        need_en_r;
  logic [1:0]  mode_done_r;
  logic [1:0]  enable_done_r;

  logic        is_front, is_back, need_mode, need_en;
  logic        fire, last_frame, frame_end;
  logic [15:0] reg_word, val_word, crc;
  logic [7:0]  tx_byte;
  crc_ctl_t    crc_ctl;

  // Set-up planning for the request being accepted.
  always_comb begin
    is_front  = (drive_addr == front_drive_address);
    is_back   = (drive_addr == back_drive_address);
    need_mode = (operation == OP_SET_SPEED) &&
                ((is_front && !mode_done_r[0]) || (is_back && !mode_done_r[1]));
    need_en   = (operation == OP_SET_SPEED) &&
                ((is_front && !enable_done_r[0]) || (is_back && !enable_done_r[1]));
    if (operation != OP_SET_SPEED) start_kind = FR_NEW_ADDR;
    else if (need_mode)             start_kind = FR_MODE;
    else if (need_en)               start_kind = FR_ENABLE;
    else                            start_kind = FR_SPEED;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SEND;
      ST_SEND: if (fire && frame_end && last_frame) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    busy = 1'b0;
    fire = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        fire = 1'b0;
      end
      ST_SEND: begin
        busy = 1'b1;
        fire = emit_ok;
      end
      default: begin
        busy = 1'b0;
        fire = 1'b0;
      end
    endcase
  end

  // Register and value words of the current frame, and the frame that follows it.
  always_comb begin
    reg_word   = REG_SPEED_LEFT;
    val_word   = val_r;
    kind_nxt   = FR_SPEED;
    last_frame = 1'b0;
    case (kind_r)
      FR_MODE: begin
        reg_word = REG_MODE;
        val_word = velocity_mode_code;
        kind_nxt = need_en_r ? FR_ENABLE : FR_SPEED;
      end
      FR_ENABLE: begin
        reg_word = REG_CONTROL;
        val_word = enable_command;
        kind_nxt = FR_SPEED;
      end
      FR_SPEED: begin
        reg_word   = side_r ? REG_SPEED_RIGHT : REG_SPEED_LEFT;
        val_word   = val_r;
        last_frame = 1'b1;
      end
      FR_NEW_ADDR: begin
        reg_word = REG_NODE_ADDR;
        val_word = val_r;
        kind_nxt = FR_SAVE;
      end
      FR_SAVE: begin
        reg_word   = REG_EEPROM_SAVE;
        val_word   = SAVE_VALUE;
        last_frame = 1'b1;
      end
      default: begin
        reg_word   = REG_SPEED_LEFT;
        last_frame = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (byte_idx_r)
      3'd0:    tx_byte = addr_r;
      3'd1:    tx_byte = FUNC_WRITE_SINGLE;
      3'd2:    tx_byte = reg_word[15:8];
      3'd3:    tx_byte = reg_word[7:0];
      3'd4:    tx_byte = val_word[15:8];
      3'd5:    tx_byte = val_word[7:0];
      3'd6:    tx_byte = crc[7:0];
      default: tx_byte = crc[15:8];
    endcase
    frame_end      = (byte_idx_r == BYTE_LAST);
    crc_ctl.update = fire && (byte_idx_r < BYTE_CRC_LO);
    crc_ctl.first  = (byte_idx_r == 3'd0);
    crc_ctl.data   = tx_byte;
    emit.valid     = fire;
    emit.tx_byte   = tx_byte;
    emit.frame_end = frame_end;
    emit.last      = frame_end && last_frame;
  end

  mrf_crc u_crc (
    .clk (clk),
    .ctl (crc_ctl),
    .crc (crc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      kind_r        <= FR_SPEED;
      byte_idx_r    <= 3'd0;
      need_en_r     <= 1'b0;
      mode_done_r   <= 2'b00;
      enable_done_r <= 2'b00;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        kind_r     <= start_kind;
        byte_idx_r <= 3'd0;
        need_en_r  <= need_en;
        // A set-up frame counts for every tracked slot whose address it matches.
        if (need_mode) mode_done_r   <= mode_done_r   | {is_back, is_front};
        if (need_en)   enable_done_r <= enable_done_r | {is_back, is_front};
      end else if (fire) begin
        byte_idx_r <= byte_idx_r + 3'd1;
        if (frame_end) kind_r <= kind_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      addr_r <= drive_addr;
      side_r <= wheel_side;
      val_r  <= command_value;
    end
  end

  a_emit_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> (state_r == ST_SEND))
    else $error("byte emitted while sequencer idle");

  a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == ST_IDLE))
    else $error("request accepted while a command is in progress");

  a_start_begins_frame: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (state_r == ST_SEND) && (byte_idx_r == 3'd0))
    else $error("command did not start at the first frame byte");

  a_mode_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(mode_done_r[0]) && !$fell(mode_done_r[1]) &&
                     !$fell(enable_done_r[0]) && !$fell(enable_done_r[1]))
    else $error("set-up flag cleared outside reset");

endmodule

>>> rtl/modbus_rtu_motor_command_framer.sv
// Top level of the Modbus RTU write-single-register command framer.
`timescale 1ns / 1ps

// Each accepted command produces one to three 8-byte Modbus RTU frames (function 0x06,
// CRC-16 low byte first) as a stream of one byte per output request. A set-speed command
// to the front or back drive is preceded once per drive by a velocity-mode frame and an
// enable frame; a change-address command sends the new address followed by an EEPROM
// save. Bytes leave at one per cycle when the output is not stalled; the single CRC
// byte-update unit takes one frame byte per cycle. in_stall is high from the accepting
// edge until the last byte of the command is loaded into the output register.
// Configuration writes are meant for idle periods only.
module modbus_rtu_motor_command_framer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [7:0]                      in_drive_addr,
  input  logic                            in_wheel_side,
  input  logic [15:0]                     in_command_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_tx_byte,
  output logic                            out_frame_end,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [mrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mrf_pkg::*;

  logic [15:0] velocity_mode_r;
  logic [15:0] enable_cmd_r;
  logic [7:0]  front_addr_r;
  logic [7:0]  back_addr_r;

  logic        out_valid_r;
  logic [7:0]  tx_byte_r;
  logic        frame_end_r;
  logic        last_r;

  logic        busy, start, emit_ok;
  emit_t       emit;

  assign start   = in_valid && !busy;
  assign emit_ok = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      velocity_mode_r <= VELOCITY_MODE_RST;
      enable_cmd_r    <= ENABLE_CMD_RST;
      front_addr_r    <= FRONT_ADDR_RST;
      back_addr_r     <= BACK_ADDR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VELOCITY_MODE: velocity_mode_r <= cfg_wdata;
        CFG_ENABLE_CMD:    enable_cmd_r    <= cfg_wdata;
        CFG_FRONT_ADDR:    front_addr_r    <= cfg_wdata[7:0];
        CFG_BACK_ADDR:     back_addr_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  mrf_seq u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .operation           (in_operation),
    .drive_addr          (in_drive_addr),
    .wheel_side          (in_wheel_side),
    .command_value       (in_command_value),
    .velocity_mode_code  (velocity_mode_r),
    .enable_command      (enable_cmd_r),
    .front_drive_address (front_addr_r),
    .back_drive_address  (back_addr_r),
    .emit_ok             (emit_ok),
    .busy                (busy),
    .emit                (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      tx_byte_r   <= emit.tx_byte;
      frame_end_r <= emit.frame_end;
      last_r      <= emit.last;
    end
  end

  assign in_stall      = busy;
  assign out_valid     = out_valid_r;
  assign out_tx_byte   = tx_byte_r;
  assign out_frame_end = frame_end_r;
  assign out_last      = last_r;

endmodule
